>>> hw/rtl/pcsma_pkg.sv
// Shared types and constants of the p-persistent CSMA sender with exponential backoff.
// Used by the sender, its register bank and step logic and the testbench; depends on nothing.
`default_nettype none

package pcsma_pkg;

  // Width of the random samples that take part in the persistence and collision draws.
  localparam int unsigned RandBits = 16;
  localparam logic [15:0] DrawMask =
      (RandBits >= 16) ? 16'hFFFF : 16'((32'd1 << RandBits) - 32'd1);

  localparam int unsigned WaitW     = 20;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;
  localparam logic [3:0]  MaxExpCap = 4'd10;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegPersistThr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSlotTicks  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAckTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxExp     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCollThr    = 3'd4;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhSense   = 3'd1,
    PhSlot    = 3'd2,
    PhAck     = 3'd3,
    PhBackoff = 3'd4
  } phase_e;

  typedef struct packed {
    logic        frame_pending;
    logic        chan_busy;
    logic        ack_seen;
    logic [15:0] persist_draw;
    logic [15:0] collide_draw;
    logic [9:0]  backoff_draw;
  } in_item_t;

  typedef struct packed {
    logic        transmit_now;
    logic        collision_flag;
    logic        frame_done;
    logic [7:0]  attempt_count;
    logic [31:0] frame_delay;
    logic [2:0]  phase_code;
  } out_item_t;

  typedef struct packed {
    logic [16:0] persist_thr;
    logic [9:0]  slot_ticks;
    logic [15:0] ack_timeout;
    logic [3:0]  max_exp;
    logic [16:0] coll_thr;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [WaitW-1:0]  wait_count;
    logic [7:0]        attempts;
    logic [31:0]       elapsed;
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/pcsma_stream_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// The payload type comes from pcsma_pkg at instantiation.
`default_nettype none

interface pcsma_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/p_persistent_csma_beb_sender.sv
// Top level of the p-persistent CSMA sender with binary exponential backoff.
// Depends on pcsma_pkg, pcsma_stream_if, pcsma_cfg_regs and pcsma_step.
//
// Usage:
//   in_i   sink channel, one transaction per time tick (pcsma_pkg::in_item_t):
//          frame request, carrier sense, ACK flag and three random samples.
//   out_o  source channel, exactly one result transaction per tick
//          (pcsma_pkg::out_item_t): transmit, collision, done, attempts,
//          delay and the phase after the tick.
//   cfg_*  write port: cfg_we_i high at a clock edge writes cfg_wdata_i into
//          register cfg_idx_i (0 persistence threshold, 1 slot length,
//          2 ACK timeout, 3 backoff exponent limit, 4 collision threshold).
//          Write only while no tick is in flight.
// Timing: a tick accepted into the input register is evaluated by pcsma_step
//   and lands in the result register once that register is free, and
//   out_o.valid rises with it. One tick per cycle sustained while out_o.ready
//   stays high; the rate is set by the combinational state update between input and result registers.
// Stall: while out_o.ready is low the result holds; one more tick is taken
//   into the input register, then in_i.ready drops until the result drains.
// Reset: phase idle, counters zero, registers at their defaults, both
//   channels empty.
`default_nettype none

module p_persistent_csma_beb_sender (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  pcsma_stream_if.sink                         in_i,
  pcsma_stream_if.source                       out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pcsma_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pcsma_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  pcsma_pkg::cfg_t      cfg;
  pcsma_pkg::in_item_t  in_data_q;
  logic                 in_vld_q, in_vld_d;
  pcsma_pkg::out_item_t out_data_q, res;
  logic                 out_vld_q, out_vld_d;
  pcsma_pkg::state_t    state_q, state_d;
  logic                 in_take;
  logic                 advance;   // input register moves into the result register

  pcsma_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pcsma_step u_step (
    .state_i (state_q),
    .item_i  (in_data_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res)
  );

  // Handshake: the result register frees as it is taken, so the input
  // register can refill in the same cycle.
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  assign in_vld_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      state_q.phase      <= pcsma_pkg::PhIdle;
      state_q.wait_count <= '0;
      state_q.attempts   <= 8'd0;
      state_q.elapsed    <= 32'd0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) state_q <= state_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) in_data_q <= in_i.data;
    if (advance) out_data_q <= res;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  // An ACK completion always returns the sender to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.frame_done |=> state_q.phase == pcsma_pkg::PhIdle)
    else $error("frame_done without return to idle");

  // A clean transmission always waits for its ACK.
  a_tx_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.transmit_now && !res.collision_flag |=> state_q.phase == pcsma_pkg::PhAck)
    else $error("clean transmission did not enter ACK wait");

  // Within a frame the attempt count never goes down.
  a_att_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.phase != pcsma_pkg::PhIdle |=> state_q.attempts >= $past(state_q.attempts))
    else $error("attempt count decreased within a frame");

  // Input backpressure only when both registers are full and the sink stalls.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && out_vld_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

  // A collision is only ever flagged on a transmission.
  a_coll_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.collision_flag |-> out_o.data.transmit_now)
    else $error("collision flagged without transmission");

endmodule

`default_nettype wire

>>> hw/rtl/pcsma_cfg_regs.sv
// Configuration register bank of the CSMA sender.
// Depends on pcsma_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module pcsma_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pcsma_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pcsma_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output pcsma_pkg::cfg_t                       cfg_o
);

  pcsma_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pcsma_pkg::RegPersistThr: cfg_d.persist_thr = cfg_wdata_i;
        pcsma_pkg::RegSlotTicks:  cfg_d.slot_ticks  = cfg_wdata_i[9:0];
        pcsma_pkg::RegAckTimeout: cfg_d.ack_timeout = cfg_wdata_i[15:0];
        pcsma_pkg::RegMaxExp:     cfg_d.max_exp     = cfg_wdata_i[3:0];
        pcsma_pkg::RegCollThr:    cfg_d.coll_thr    = cfg_wdata_i;
        default: ; // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.persist_thr <= 17'd32768;
      cfg_q.slot_ticks  <= 10'd5;
      cfg_q.ack_timeout <= 16'd200;
      cfg_q.max_exp     <= 4'd6;
      cfg_q.coll_thr    <= 17'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/pcsma_step.sv
// One-tick transition of the sender: next state and result from state, item and config.
// Purely combinational; depends on pcsma_pkg.
`default_nettype none

module pcsma_step (
  input  wire pcsma_pkg::state_t    state_i,
  input  wire pcsma_pkg::in_item_t  item_i,
  input  wire pcsma_pkg::cfg_t      cfg_i,
  output pcsma_pkg::state_t         state_o,
  output pcsma_pkg::out_item_t      res_o
);

  logic [15:0]                  pdraw, cdraw;
  logic                         sense, backoff_go;
  logic                         tx, coll, done;
  logic [31:0]                  delay;
  logic [7:0]                   att_inc;
  logic [3:0]                   exp_raw, exp_lim;
  logic [9:0]                   slot_mask, slots;
  logic [pcsma_pkg::WaitW-1:0]  bo_ticks;
  pcsma_pkg::state_t            st;

  assign pdraw = item_i.persist_draw & pcsma_pkg::DrawMask;
  assign cdraw = item_i.collide_draw & pcsma_pkg::DrawMask;

  always_comb begin
    st         = state_i;
    sense      = 1'b0;
    backoff_go = 1'b0;
    tx         = 1'b0;
    coll       = 1'b0;
    done       = 1'b0;
    delay      = 32'd0;
    att_inc    = 8'd0;
    exp_raw    = 4'd0;
    exp_lim    = 4'd0;
    slot_mask  = 10'd0;
    slots      = 10'd0;
    bo_ticks   = '0;

    if (state_i.phase == pcsma_pkg::PhIdle) begin
      if (item_i.frame_pending) begin
        // frame start: sense in this same tick
        st.attempts = 8'd0;
        st.elapsed  = 32'd0;
        sense       = 1'b1;
      end
    end else begin
      if (st.elapsed != 32'hFFFF_FFFF) st.elapsed = st.elapsed + 32'd1;
      case (state_i.phase)
        pcsma_pkg::PhSense: sense = 1'b1;
        pcsma_pkg::PhSlot, pcsma_pkg::PhBackoff: begin
          if (st.wait_count <= 20'd1) begin
            st.wait_count = '0;
            st.phase      = pcsma_pkg::PhSense;
          end else begin
            st.wait_count = st.wait_count - 20'd1;
          end
        end
        pcsma_pkg::PhAck: begin
          if (item_i.ack_seen) begin
            done          = 1'b1;
            delay         = st.elapsed;
            st.phase      = pcsma_pkg::PhIdle;
            st.wait_count = '0;
          end else if (st.wait_count <= 20'd1) begin
            backoff_go = 1'b1;  // timeout (a zero timeout acts as one tick)
          end else begin
            st.wait_count = st.wait_count - 20'd1;
          end
        end
        default: begin
          st.phase      = pcsma_pkg::PhIdle;
          st.wait_count = '0;
        end
      endcase
    end

    if (sense) begin
      if (item_i.chan_busy || !({1'b0, pdraw} < cfg_i.persist_thr)) begin
        if (cfg_i.slot_ticks == 10'd0) begin
          st.phase      = pcsma_pkg::PhSense;
          st.wait_count = '0;
        end else begin
          st.phase      = pcsma_pkg::PhSlot;
          st.wait_count = {10'd0, cfg_i.slot_ticks};
        end
      end else begin
        tx = 1'b1;
        if ({1'b0, cdraw} < cfg_i.coll_thr) begin
          coll       = 1'b1;
          backoff_go = 1'b1;
        end else begin
          st.phase      = pcsma_pkg::PhAck;
          st.wait_count = {4'd0, cfg_i.ack_timeout};
        end
      end
    end

    if (backoff_go) begin
      att_inc     = (st.attempts == 8'hFF) ? st.attempts : st.attempts + 8'd1;
      st.attempts = att_inc;
      exp_raw     = (att_inc < {4'd0, cfg_i.max_exp}) ? att_inc[3:0] : cfg_i.max_exp;
      exp_lim     = (exp_raw > pcsma_pkg::MaxExpCap) ? pcsma_pkg::MaxExpCap : exp_raw;
      slot_mask   = 10'((11'd1 << exp_lim) - 11'd1);
      slots       = item_i.backoff_draw & slot_mask;
      bo_ticks    = pcsma_pkg::WaitW'({10'd0, slots} * {10'd0, cfg_i.slot_ticks});
      if (bo_ticks == '0) begin
        st.phase      = pcsma_pkg::PhSense;
        st.wait_count = '0;
      end else begin
        st.phase      = pcsma_pkg::PhBackoff;
        st.wait_count = bo_ticks;
      end
    end
  end

  assign state_o            = st;
  assign res_o.transmit_now   = tx;
  assign res_o.collision_flag = coll;
  assign res_o.frame_done     = done;
  assign res_o.attempt_count  = st.attempts;
  assign res_o.frame_delay    = delay;
  assign res_o.phase_code     = st.phase;

endmodule

`default_nettype wire

>>> test/pcsma_sender_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the p-persistent CSMA sender: follows the register port, predicts each
// result tick by tick and compares it with the result channel. Depends on pcsma_pkg.
module pcsma_sender_checker
  import pcsma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_valid_i,
  input  logic                tick_ready_i,
  input  in_item_t            tick_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  out_item_t           res_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);

  // Predicted sender state and register copy
  phase_e           ph;
  logic [WaitW-1:0] wait_cnt;
  logic [7:0]       tries;
  logic [31:0]      elapsed;
  cfg_t             cfg;

  out_item_t expected_results[$];

  function automatic void enter_wait(input phase_e kind, input int unsigned ticks);
    ticks = ticks & 32'hFFFFF;
    if (ticks == 0) begin
      ph       = PhSense;
      wait_cnt = '0;
    end else begin
      ph       = kind;
      wait_cnt = ticks[WaitW-1:0];
    end
  endfunction

  // One more failed attempt, then wait a masked number of slots
  function automatic void start_backoff(input logic [9:0] draw);
    int unsigned e;
    if (tries != 8'hFF) tries++;
    e = (tries < cfg.max_exp) ? tries : cfg.max_exp;
    if (e > MaxExpCap) e = MaxExpCap;
    enter_wait(PhBackoff, (draw & ((32'd1 << e) - 32'd1)) * cfg.slot_ticks);
  endfunction

  function automatic out_item_t advance_sender(input in_item_t t);
    out_item_t   r;
    logic [15:0] p_draw;
    logic [15:0] c_draw;
    logic        sense;
    r      = '0;
    p_draw = t.persist_draw & DrawMask;
    c_draw = t.collide_draw & DrawMask;
    sense  = 1'b0;
    if (ph == PhIdle) begin
      if (t.frame_pending) begin
        tries   = '0;
        elapsed = '0;
        sense   = 1'b1;
      end
    end else begin
      if (elapsed != '1) elapsed++;
      case (ph)
        PhSense: sense = 1'b1;
        PhSlot, PhBackoff: begin
          if (wait_cnt <= 1) begin
            wait_cnt = '0;
            ph       = PhSense;
          end else wait_cnt--;
        end
        PhAck: begin
          // an ACK on the expiring tick still wins over the timeout
          if (t.ack_seen) begin
            r.frame_done  = 1'b1;
            r.frame_delay = elapsed;
            ph            = PhIdle;
            wait_cnt      = '0;
          end else if (wait_cnt <= 1) start_backoff(t.backoff_draw);
          else wait_cnt--;
        end
        default: begin
          ph       = PhIdle;
          wait_cnt = '0;
        end
      endcase
    end
    if (sense) begin
      if (t.chan_busy || !({1'b0, p_draw} < cfg.persist_thr)) begin
        enter_wait(PhSlot, cfg.slot_ticks);
      end else begin
        r.transmit_now = 1'b1;
        if ({1'b0, c_draw} < cfg.coll_thr) begin
          r.collision_flag = 1'b1;
          start_backoff(t.backoff_draw);
        end else begin
          ph       = PhAck;
          wait_cnt = WaitW'(cfg.ack_timeout);
        end
      end
    end
    r.attempt_count = tries;
    r.phase_code    = ph;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      ph              = PhIdle;
      wait_cnt        = '0;
      tries           = '0;
      elapsed         = '0;
      cfg.persist_thr = 17'd32768;
      cfg.slot_ticks  = 10'd5;
      cfg.ack_timeout = 16'd200;
      cfg.max_exp     = 4'd6;
      cfg.coll_thr    = 17'd0;
      expected_results.delete();
      mismatches_o    = 0;
      outstanding_o   = 0;
    end else begin
      // results first: a tick taken at this edge cannot have its result here yet
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing actual %h",
                   $time, res_data_i);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("transmit_now", want.transmit_now, res_data_i.transmit_now);
          check_field("collision_flag", want.collision_flag, res_data_i.collision_flag);
          check_field("frame_done", want.frame_done, res_data_i.frame_done);
          check_field("attempt_count", want.attempt_count, res_data_i.attempt_count);
          check_field("frame_delay", want.frame_delay, res_data_i.frame_delay);
          check_field("phase_code", want.phase_code, res_data_i.phase_code);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPersistThr: cfg.persist_thr = cfg_wdata_i;
          RegSlotTicks:  cfg.slot_ticks  = cfg_wdata_i[9:0];
          RegAckTimeout: cfg.ack_timeout = cfg_wdata_i[15:0];
          RegMaxExp:     cfg.max_exp     = cfg_wdata_i[3:0];
          RegCollThr:    cfg.coll_thr    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) expected_results.push_back(advance_sender(tick_data_i));
      outstanding_o = expected_results.size();
    end
  end

endmodule

>>> test/tb_p_persistent_csma_beb_sender.sv
`timescale 1ns / 1ps
// Top of the CSMA sender testbench: clock, reset, tick stimulus, register writes and verdict.
// Depends on pcsma_pkg, pcsma_stream_if, the sender RTL and pcsma_sender_checker.
module tb_p_persistent_csma_beb_sender;
  import pcsma_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  // register write port
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  pcsma_stream_if #(.payload_t(in_item_t))  tick_if ();
  pcsma_stream_if #(.payload_t(out_item_t)) result_if ();

  int mismatches;
  int outstanding;

  p_persistent_csma_beb_sender u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (tick_if),
    .out_o       (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pcsma_sender_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_valid_i  (tick_if.valid),
    .tick_ready_i  (tick_if.ready),
    .tick_data_i   (tick_if.data),
    .res_valid_i   (result_if.valid),
    .res_ready_i   (result_if.ready),
    .res_data_i    (result_if.data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Stimulus knobs: percent chances of the flag fields, and quiet stretches
  // where one side or the other never idles.
  int   pend_pct = 60;
  int   busy_pct = 25;
  int   ack_pct  = 15;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  cfg_t cur_cfg;

  // Watchdog: a stuck handshake or a lost result ends up here.
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: after each transaction ready may be held low for a random stall; rx_quiet keeps it high.
  // ready moves only at the falling edge, so the DUT and the checker see it settled.
  int rx_hold = 0;
  initial begin
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        result_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        result_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) rx_hold = rx_quiet ? 0 : $urandom_range(0, 9);
    end
  end

  function automatic in_item_t tick(input logic pend, input logic busy, input logic ack,
                                    input logic [15:0] p_draw, input logic [15:0] c_draw,
                                    input logic [9:0] b_draw);
    in_item_t t;
    t.frame_pending = pend;
    t.chan_busy     = busy;
    t.ack_seen      = ack;
    t.persist_draw  = p_draw;
    t.collide_draw  = c_draw;
    t.backoff_draw  = b_draw;
    return t;
  endfunction

  function automatic cfg_t mk_cfg(input logic [16:0] p_thr, input logic [9:0] slot,
                                  input logic [15:0] ack_to, input logic [3:0] max_exp,
                                  input logic [16:0] c_thr);
    cfg_t c;
    c.persist_thr = p_thr;
    c.slot_ticks  = slot;
    c.ack_timeout = ack_to;
    c.max_exp     = max_exp;
    c.coll_thr    = c_thr;
    return c;
  endfunction

  // Draws cluster around the threshold edge now and then, so the strict compare
  // gets hit from both sides; otherwise full-range random.
  function automatic logic [15:0] draw_near(input logic [16:0] thr);
    case ($urandom_range(0, 7))
      0:       return 16'(thr - 17'd1);
      1:       return thr[15:0];
      2:       return '0;
      3:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_tick();
    in_item_t t;
    t.frame_pending = ($urandom_range(0, 99) < pend_pct);
    t.chan_busy     = ($urandom_range(0, 99) < busy_pct);
    t.ack_seen      = ($urandom_range(0, 99) < ack_pct);
    t.persist_draw  = draw_near(cur_cfg.persist_thr);
    t.collide_draw  = draw_near(cur_cfg.coll_thr);
    case ($urandom_range(0, 7))
      0:       t.backoff_draw = '0;
      1:       t.backoff_draw = '1;
      default: t.backoff_draw = 10'($urandom);
    endcase
    return t;
  endfunction

  // Send one tick transaction after a random gap. valid stays high across
  // back-to-back ticks; it only drops when a gap is drawn.
  task automatic send_tick(input in_item_t t);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk_i);
      tick_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    tick_if.valid <= 1'b1;
    tick_if.data  <= t;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic drain();
    @(negedge clk_i);
    tick_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Program every register, plus one write to an unmapped index that must be dropped.
  // Only called with the block drained.
  task automatic apply_cfg(input cfg_t c);
    write_reg(RegPersistThr, c.persist_thr);
    write_reg(RegSlotTicks, CfgDataW'(c.slot_ticks));
    write_reg(RegAckTimeout, CfgDataW'(c.ack_timeout));
    write_reg(RegMaxExp, CfgDataW'(c.max_exp));
    write_reg(RegCollThr, c.coll_thr);
    write_reg(RegCollThr + CfgIdxW'($urandom_range(1, 3)), CfgDataW'($urandom));
    cur_cfg = c;
  endtask

  task automatic run_random(input int n, input bit mid_drain);
    for (int i = 0; i < n; i++) begin
      // reshuffle idling every 50 ticks; about a quarter of the stretches are gap-free
      if (i % 50 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      // sender holds off mid-phase until the result queue is empty
      if (mid_drain && i == n / 2) drain();
      send_tick(random_tick());
    end
  endtask

  initial begin
    cfg_t c;
    rst_ni        = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    cur_cfg       = mk_cfg(17'd32768, 10'd5, 16'd200, 4'd6, 17'd0);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed, register defaults (p = 1/2, slot 5, timeout 200) ---
    // idle with a stray ACK and busy channel: nothing happens
    send_tick(tick(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 10'h3FF));
    // frame start senses the same tick; busy -> one slot wait
    send_tick(tick(1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 10'h000));
    // slot wait; pending and ACK are both stray here
    repeat (5) send_tick(tick(1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 10'h000));
    // draw equal to the threshold does not pass
    send_tick(tick(1'b0, 1'b0, 1'b0, 16'd32768, 16'h0000, 10'h000));
    repeat (5) send_tick(tick(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 10'h000));
    // draw just below: transmit, no collision at threshold 0
    send_tick(tick(1'b0, 1'b0, 1'b0, 16'd32767, 16'hFFFF, 10'h000));
    // ACK completes the frame and reports its delay
    send_tick(tick(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 10'h3FF));
    drain();

    // --- p = 1, slot 1, timeout 3, full exponent range ---
    apply_cfg(mk_cfg(17'd65536, 10'd1, 16'd3, 4'd10, 17'd0));
    send_tick(tick(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 10'h000));
    repeat (2) send_tick(tick(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 10'h000));
    // ACK on the tick the timeout runs out still completes
    send_tick(tick(1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 10'h000));
    send_tick(tick(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 10'h000));
    // no ACK: timeout, first backoff
    repeat (3) send_tick(tick(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 10'h3FF));
    ack_pct = 20;
    run_random(100, 1'b0);
    drain();

    // --- every transmission collides, zero-length backoff: attempts run into 255 ---
    apply_cfg(mk_cfg(17'd65536, 10'd1, 16'd1, 4'd0, 17'd65536));
    pend_pct = 100;
    busy_pct = 0;
    ack_pct  = 0;
    run_random(320, 1'b0);
    drain();

    // --- attempts still saturated, exponent capped at 10, mostly collisions ---
    apply_cfg(mk_cfg(17'd65536, 10'd1, 16'd2, 4'd10, 17'd60000));
    pend_pct = 60;
    busy_pct = 10;
    ack_pct  = 20;
    run_random(150, 1'b1);
    drain();

    // --- long slot and longest timeout ---
    apply_cfg(mk_cfg(17'd65535, 10'd1000, 16'd65535, 4'd10, 17'd0));
    busy_pct = 5;
    ack_pct  = 30;
    run_random(80, 1'b0);
    drain();

    // --- random settings with short waits; first one never passes persistence ---
    busy_pct = 25;
    ack_pct  = 15;
    for (int k = 0; k < 5; k++) begin
      case ($urandom_range(0, 3))
        0:       c.persist_thr = 17'd0;
        1:       c.persist_thr = 17'd65536;
        default: c.persist_thr = 17'($urandom_range(16384, 65536));
      endcase
      if (k == 0) c.persist_thr = 17'd0;
      c.slot_ticks  = 10'($urandom_range(1, 6));
      c.ack_timeout = 16'($urandom_range(1, 30));
      c.max_exp     = 4'($urandom_range(0, 10));
      case ($urandom_range(0, 3))
        0:       c.coll_thr = 17'd0;
        1:       c.coll_thr = 17'd65536;
        default: c.coll_thr = 17'($urandom_range(0, 40000));
      endcase
      apply_cfg(c);
      run_random(110, 1'b0);
      drain();
    end

    // pipeline holds an input and a result register; the wait below catches any stray result
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pcsma_pkg.sv
hw/rtl/pcsma_stream_if.sv
hw/rtl/pcsma_cfg_regs.sv
hw/rtl/pcsma_step.sv
hw/rtl/p_persistent_csma_beb_sender.sv
test/pcsma_sender_checker.sv
test/tb_p_persistent_csma_beb_sender.sv
